>>> hdl/drpk_pkg.sv
// ----------------------------------------------------------------------------
// drpk_pkg
// Shared types and constants for the DER RSA private key parser.
// ----------------------------------------------------------------------------
package drpk_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEQ_LEN = 3'd1,
    PH_VERSION = 3'd2,
    PH_INT_TAG = 3'd3,
    PH_INT_LEN = 3'd4,
    PH_INT_VAL = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAG  = 2'd1,
    ST_LONG_LEN = 2'd2,
    ST_TOO_WIDE = 2'd3
  } status_t;

  localparam logic [7:0] SEQ_TAG       = 8'h30;
  localparam logic [7:0] LONG_FORM     = 8'h80;
  localparam logic [7:0] MAX_INT_BYTES = 8'd9;
  localparam logic [2:0] VERSION_BYTES = 3'd3;
  localparam logic [2:0] LAST_INDEX    = 3'd7;

  typedef struct packed {
    logic [2:0]  field_index;
    logic [63:0] value;
    status_t     status;
    logic        last;
  } result_t;

endpackage

>>> hdl/drpk_core.sv
// ----------------------------------------------------------------------------
// drpk_core
// Parse state and one-byte step logic: header checks, integer length and
// value accumulation, result generation.
// ----------------------------------------------------------------------------
module drpk_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             start_req,
  output logic             res_valid,
  output drpk_pkg::result_t res
);
  import drpk_pkg::*;

  phase_t      parse_phase, parse_phase_next;
  logic [2:0]  header_position, header_position_next;
  logic [3:0]  bytes_remaining, bytes_remaining_next;
  logic [63:0] accumulator, accumulator_next;
  logic [2:0]  integer_count, integer_count_next;
  logic        first_value_byte, first_value_byte_next;

  logic [2:0]  hp_inc;
  logic [3:0]  br_dec;
  logic [63:0] acc_shift;
  logic        final_int;

  assign hp_inc    = header_position + 3'd1;
  assign br_dec    = bytes_remaining - 4'd1;
  assign acc_shift = {accumulator[55:0], data_byte};
  assign final_int = (integer_count == LAST_INDEX);

  always_comb begin
    parse_phase_next      = parse_phase;
    header_position_next  = header_position;
    bytes_remaining_next  = bytes_remaining;
    accumulator_next      = accumulator;
    integer_count_next    = integer_count;
    first_value_byte_next = first_value_byte;
    res_valid             = 1'b0;
    res.field_index       = 3'd0;
    res.value             = 64'd0;
    res.status            = ST_OK;
    res.last              = 1'b0;

    if (start_req) begin
      header_position_next  = 3'd0;
      bytes_remaining_next  = 4'd0;
      accumulator_next      = 64'd0;
      integer_count_next    = 3'd0;
      first_value_byte_next = 1'b0;
      if (data_byte != SEQ_TAG) begin
        parse_phase_next = PH_IDLE;
        res_valid        = 1'b1;
        res.status       = ST_BAD_TAG;
        res.last         = 1'b1;
      end else begin
        parse_phase_next = PH_SEQ_LEN;
      end
    end else begin
      case (parse_phase)
        PH_IDLE: begin
          parse_phase_next = PH_IDLE;
        end
        PH_SEQ_LEN: begin
          if (data_byte >= LONG_FORM) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.status       = ST_LONG_LEN;
            res.last         = 1'b1;
          end else begin
            header_position_next = 3'd0;
            parse_phase_next     = PH_VERSION;
          end
        end
        PH_VERSION: begin
          header_position_next = hp_inc;
          if (hp_inc >= VERSION_BYTES) parse_phase_next = PH_INT_TAG;
        end
        PH_INT_TAG: begin
          parse_phase_next = PH_INT_LEN;
        end
        PH_INT_LEN: begin
          accumulator_next = 64'd0;
          if (data_byte > MAX_INT_BYTES) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.field_index  = integer_count;
            res.status       = ST_TOO_WIDE;
            res.last         = 1'b1;
          end else if (data_byte == 8'd0) begin
            // empty integer: emit zero right at the length byte
            res_valid          = 1'b1;
            res.field_index    = integer_count;
            res.last           = final_int;
            integer_count_next = integer_count + 3'd1;
            parse_phase_next   = final_int ? PH_IDLE : PH_INT_TAG;
          end else begin
            bytes_remaining_next  = data_byte[3:0];
            first_value_byte_next = (data_byte == MAX_INT_BYTES);
            parse_phase_next      = PH_INT_VAL;
          end
        end
        PH_INT_VAL: begin
          if (first_value_byte && (data_byte != 8'd0)) begin
            parse_phase_next = PH_IDLE;
            res_valid        = 1'b1;
            res.field_index  = integer_count;
            res.status       = ST_TOO_WIDE;
            res.last         = 1'b1;
          end else begin
            first_value_byte_next = 1'b0;
            accumulator_next      = acc_shift;
            bytes_remaining_next  = br_dec;
            if (br_dec == 4'd0) begin
              res_valid          = 1'b1;
              res.field_index    = integer_count;
              res.value          = acc_shift;
              res.last           = final_int;
              integer_count_next = integer_count + 3'd1;
              parse_phase_next   = final_int ? PH_IDLE : PH_INT_TAG;
            end
          end
        end
        default: begin
          parse_phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_IDLE;
      header_position  <= 3'd0;
      bytes_remaining  <= 4'd0;
      accumulator      <= 64'd0;
      integer_count    <= 3'd0;
      first_value_byte <= 1'b0;
    end else if (step) begin
      parse_phase      <= parse_phase_next;
      header_position  <= header_position_next;
      bytes_remaining  <= bytes_remaining_next;
      accumulator      <= accumulator_next;
      integer_count    <= integer_count_next;
      first_value_byte <= first_value_byte_next;
    end
  end

endmodule

>>> hdl/der_rsa_private_key_parser_unit.sv
// ----------------------------------------------------------------------------
// der_rsa_private_key_parser_unit
// Streaming DER RSA private key parser with registered input and result.
// ----------------------------------------------------------------------------
// Takes one byte of a DER-encoded RSA private key per beat (start_req marks
// the SEQUENCE tag of a new key) and returns one beat per decoded INTEGER,
// carrying its index, its value (up to 64 bits), a status code and a last
// flag on the final beat of a key (eighth integer or any error). The block
// sustains one input byte per clock cycle while input is not stalled; each byte
// passes an input register, a single step of the parse state in drpk_core, and
// the result register, which presents the result until the receiver takes it.
// A result that is not taken stalls input only when the next byte also
// produces a result.
module der_rsa_private_key_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  field_index,
  output logic [63:0] value,
  output logic [1:0]  status,
  output logic        last
);
  import drpk_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_adv;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  drpk_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .data_byte (s1_byte),
    .start_req (s1_start),
    .res_valid (res_valid),
    .res       (res)
  );

  // advance unless a result must wait for a full output register
  assign s1_adv   = s1_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_res <= res;
    end
  end

  assign field_index = out_res.field_index;
  assign value       = out_res.value;
  assign status      = out_res.status;
  assign last        = out_res.last;

endmodule
